/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* sv/psi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package psi_pkg;

  localparam int POS_W = 10;
  localparam int FL_W = 10;
  localparam int TIME_W = 16;
  localparam int IDX_W = 5;
  localparam int DVD_W = 16;
  localparam int DVS_W = 17;
  localparam int CENTER_RAW = 512;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic KIND_GOAL = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FDIV,
    S_MRD,
    S_MDIV,
    S_TUPD,
    S_EMIT,
    S_IOUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic cur_we;
    logic tgt_we;
    logic stp_we;
  } mem_we_t;

endpackage
`default_nettype wire

/* sv/psi_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module psi_div import psi_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DVS_W-1:0]  divisor,
  output div_stat_t              stat,
  output logic      [DVD_W-1:0]  quotient
);

  localparam int CNW = $clog2(DVD_W);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] q;
  logic [CNW-1:0]   cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial = {rem, q[DVD_W-1]};
    ge = trial >= {1'b0, dvs};
    diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNW'(DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      // shift one dividend bit in, keep the quotient bit
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      q <= {q[DVD_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient = q;

endmodule
`default_nettype wire

/* sv/psi_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module psi_mem import psi_pkg::*; #(
  parameter int NUM = 18,
  parameter int PW = 13,
  parameter int SW = 14,
  parameter int CW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mem_we_t       we,
  input  wire logic [CW-1:0] waddr,
  input  wire logic [PW-1:0] cur_wdata,
  input  wire logic [PW-1:0] tgt_wdata,
  input  wire logic [SW-1:0] stp_wdata,
  input  wire logic [CW-1:0] raddr,
  output logic      [PW-1:0] cur_rdata,
  output logic      [PW-1:0] tgt_rdata,
  output logic      [SW-1:0] stp_rdata
);

  localparam logic [PW-1:0] CENTER = PW'(CENTER_RAW) << (PW - POS_W);

  logic [PW-1:0] cur_mem [NUM];
  logic [PW-1:0] tgt_mem [NUM];
  logic [SW-1:0] stp_mem [NUM];
  logic [NUM-1:0] cur_vld;
  logic [NUM-1:0] tgt_vld;
  logic [PW-1:0] cur_q;
  logic [PW-1:0] tgt_q;
  logic          cur_vq;
  logic          tgt_vq;
  logic          hit;

  assign hit = (waddr == raddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= '0;
      tgt_vld <= '0;
    end else begin
      if (we.cur_we) cur_vld[waddr] <= 1'b1;
      if (we.tgt_we) tgt_vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we.cur_we) cur_mem[waddr] <= cur_wdata;
    if (we.tgt_we) tgt_mem[waddr] <= tgt_wdata;
    if (we.stp_we) stp_mem[waddr] <= stp_wdata;
    // forward a write to the entry read at the same edge
    if (we.cur_we && hit) begin
      cur_q <= cur_wdata;
      cur_vq <= 1'b1;
    end else begin
      cur_q <= cur_mem[raddr];
      cur_vq <= cur_vld[raddr];
    end
    if (we.tgt_we && hit) begin
      tgt_q <= tgt_wdata;
      tgt_vq <= 1'b1;
    end else begin
      tgt_q <= tgt_mem[raddr];
      tgt_vq <= tgt_vld[raddr];
    end
    if (we.stp_we && hit) stp_rdata <= stp_wdata;
    else stp_rdata <= stp_mem[raddr];
  end

  assign cur_rdata = cur_vq ? cur_q : CENTER;
  assign tgt_rdata = tgt_vq ? tgt_q : CENTER;

endmodule
`default_nettype wire

/* sv/multi_servo_pose_interpolator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Load and target ops write one entry; a move start divides the move time by
// the frame length, then once per servo, on the shared 16-step serial divider.
// A tick while moving does a read-modify-write of each servo in the pose memory,
// then gives one result per servo; an idle tick gives one result.
// Synchronous active-high reset: idle, not moving, all poses at center, frame 33.
module multi_servo_pose_interpolator_core import psi_pkg::*; #(
  parameter int NUM_SERVOS = 18,
  parameter int FRAC_BITS = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [IDX_W-1:0]   servo_index,
  input  wire logic [POS_W-1:0]   position,
  input  wire logic [TIME_W-1:0]  move_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic      [IDX_W-1:0]   servo_index_res,
  output logic      [POS_W-1:0]   goal_raw,
  output logic                    last,
  output logic                    moving,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FL_W-1:0]    cfg_data
);

  `include "assert_macros.svh"

  localparam int PW = POS_W + FRAC_BITS;
  localparam int SW = PW + 1;
  localparam int CW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_SERVOS - 1);

  state_t           state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             active, active_next;
  logic             arr_all, arr_all_next;
  logic [FL_W-1:0]  frame_length;
  logic [DVS_W-1:0] frames;
  logic             accept;
  logic             idx_ok;
  logic             out_ok;

  div_stat_t        dstat;
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] quot;

  mem_we_t          we;
  logic [CW-1:0]    waddr;
  logic [PW-1:0]    cur_wdata, tgt_wdata;
  logic [SW-1:0]    stp_wdata;
  logic [PW-1:0]    cur_rd, tgt_rd;
  logic [SW-1:0]    stp_rd;

  logic [SW-1:0]    cur_x, tgt_x, span, new_pos;
  logic             arr;

  logic             load;
  logic             ld_kind, ld_last;
  logic [IDX_W-1:0] ld_idx;
  logic [POS_W-1:0] ld_goal;

  psi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (dstat),
    .quotient (quot)
  );

  psi_mem #(
    .NUM (NUM_SERVOS),
    .PW  (PW),
    .SW  (SW),
    .CW  (CW)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .we        (we),
    .waddr     (waddr),
    .cur_wdata (cur_wdata),
    .tgt_wdata (tgt_wdata),
    .stp_wdata (stp_wdata),
    .raddr     (cnt_next),
    .cur_rdata (cur_rd),
    .tgt_rdata (tgt_rd),
    .stp_rdata (stp_rd)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign idx_ok = {1'b0, servo_index} < (IDX_W + 1)'(NUM_SERVOS);
  assign out_ok = !out_valid || !out_stall;

  // step one servo toward its target
  always_comb begin
    cur_x = {1'b0, cur_rd};
    tgt_x = {1'b0, tgt_rd};
    span = (tgt_x > cur_x) ? (tgt_x - cur_x) : (cur_x - tgt_x);
    arr = 1'b0;
    new_pos = cur_x;
    if (cur_x == tgt_x) begin
      arr = 1'b1;
    end else if (span < stp_rd) begin
      arr = 1'b1;
      new_pos = tgt_x;
    end else if (tgt_x > cur_x) begin
      new_pos = cur_x + stp_rd;
    end else begin
      new_pos = cur_x - stp_rd;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    active_next = active;
    arr_all_next = arr_all;
    div_start = 1'b0;
    div_dvd = move_time;
    div_dvs = (frame_length == '0) ? DVS_W'(1) : DVS_W'(frame_length);
    we = '0;
    waddr = cnt;
    cur_wdata = new_pos[PW-1:0];
    tgt_wdata = PW'(position) << FRAC_BITS;
    stp_wdata = SW'(quot) + SW'(1);
    load = 1'b0;
    ld_kind = KIND_GOAL;
    ld_idx = IDX_W'(cnt);
    ld_goal = cur_rd[PW-1:FRAC_BITS];
    ld_last = (cnt == LAST_IDX);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              we.cur_we = idx_ok;
              waddr = CW'(servo_index);
              cur_wdata = PW'(position) << FRAC_BITS;
            end
            OP_TARGET: begin
              we.tgt_we = idx_ok;
              waddr = CW'(servo_index);
            end
            OP_START: begin
              div_start = 1'b1;
              state_next = S_FDIV;
            end
            OP_TICK: begin
              if (active) begin
                cnt_next = '0;
                arr_all_next = 1'b1;
                state_next = S_TUPD;
              end else begin
                state_next = S_IOUT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FDIV: begin
        if (dstat.done) begin
          cnt_next = '0;
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        div_start = 1'b1;
        div_dvd = DVD_W'(span);
        div_dvs = frames;
        state_next = S_MDIV;
      end
      S_MDIV: begin
        if (dstat.done) begin
          we.stp_we = 1'b1;
          if (cnt == LAST_IDX) begin
            active_next = 1'b1;
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
            state_next = S_MRD;
          end
        end
      end
      S_TUPD: begin
        we.cur_we = 1'b1;
        arr_all_next = arr_all && arr;
        if (cnt == LAST_IDX) begin
          active_next = !(arr_all && arr);
          cnt_next = '0;
          state_next = S_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ok) begin
          load = 1'b1;
          if (cnt == LAST_IDX) state_next = S_IDLE;
          else cnt_next = cnt + 1'b1;
        end
      end
      S_IOUT: begin
        ld_kind = KIND_IDLE;
        ld_idx = '0;
        ld_goal = '0;
        ld_last = 1'b1;
        if (out_ok) begin
          load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      active <= 1'b0;
      arr_all <= 1'b1;
      frame_length <= FL_W'(33);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      active <= active_next;
      arr_all <= arr_all_next;
      if (cfg_valid && cfg_ready) frame_length <= cfg_data;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FDIV && dstat.done) frames <= DVS_W'(quot) + DVS_W'(1);
    if (load) begin
      kind <= ld_kind;
      servo_index_res <= ld_idx;
      goal_raw <= ld_goal;
      last <= ld_last;
      moving <= active;
    end
  end

  `ASSERT_IMP(a_idle_item, clk, rst, out_valid && kind == KIND_IDLE, last && !moving)
  `ASSERT_IMP(a_busy_stall, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_NXT(a_active_set, clk, rst, !active && state != S_MDIV, !active)

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb import psi_pkg::*; ();

  localparam int NSERVO = 18;
  localparam int FRAC = 3;
  localparam int POSW = POS_W + FRAC;
  localparam int IDLE_LIMIT = 40000;
  localparam int TAIL_CYCLES = 400;
  localparam int RANDOM_ITEMS = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = OP_LOAD;
  logic [IDX_W-1:0] servo_index = '0;
  logic [POS_W-1:0] position = '0;
  logic [TIME_W-1:0] move_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [IDX_W-1:0] servo_index_res;
  logic [POS_W-1:0] goal_raw;
  logic last;
  logic moving;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FL_W-1:0] cfg_data = '0;

  multi_servo_pose_interpolator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .servo_index(servo_index), .position(position), .move_time(move_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .servo_index_res(servo_index_res), .goal_raw(goal_raw),
    .last(last), .moving(moving),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic kind;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] goal;
    logic last;
    logic moving;
  } goal_t;

  typedef struct {
    logic [1:0] op;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic [TIME_W-1:0] mtime;
    logic typed;
    goal_t first_goal;
  } stim_t;

  // shadow pose state
  logic [POSW-1:0] cur_pose[NSERVO];
  logic [POSW-1:0] tgt_pose[NSERVO];
  logic [POSW-1:0] step_pose[NSERVO];
  logic in_motion;
  logic [FL_W-1:0] frame_ms;

  goal_t pending_goals[$];
  int errors = 0;
  int idle_cycles = 0;
  int goals_seen = 0;
  int items_sent = 0;
  int moves_started = 0;
  bit in_acc, out_acc;
  bit rx_gap_long = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic pose_reset();
    for (int i = 0; i < NSERVO; i++) begin
      cur_pose[i] = POSW'(CENTER_RAW) << FRAC;
      tgt_pose[i] = POSW'(CENTER_RAW) << FRAC;
      step_pose[i] = '0;
    end
    in_motion = 1'b0;
    frame_ms = 10'd33;
  endtask

  task automatic predict_pose(input stim_t s);
    int fl, frames, span, left;
    goal_t g;
    case (s.op)
      OP_LOAD: if (s.idx < NSERVO) cur_pose[s.idx] = POSW'(s.pos) << FRAC;
      OP_TARGET: if (s.idx < NSERVO) tgt_pose[s.idx] = POSW'(s.pos) << FRAC;
      OP_START: begin
        fl = (frame_ms == 0) ? 1 : frame_ms;
        frames = s.mtime / fl + 1;
        for (int i = 0; i < NSERVO; i++) begin
          span = (tgt_pose[i] > cur_pose[i]) ? tgt_pose[i] - cur_pose[i]
                                             : cur_pose[i] - tgt_pose[i];
          step_pose[i] = POSW'(span / frames + 1);
        end
        in_motion = 1'b1;
        moves_started++;
      end
      default: begin
        if (!in_motion) begin
          g = '{kind: KIND_IDLE, idx: '0, goal: '0, last: 1'b1, moving: 1'b0};
          pending_goals.push_back(g);
        end else begin
          left = NSERVO;
          for (int i = 0; i < NSERVO; i++) begin
            if (cur_pose[i] == tgt_pose[i]) left--;
            else if (tgt_pose[i] > cur_pose[i]) begin
              if (tgt_pose[i] - cur_pose[i] < step_pose[i]) begin
                cur_pose[i] = tgt_pose[i];
                left--;
              end else cur_pose[i] = cur_pose[i] + step_pose[i];
            end else begin
              if (cur_pose[i] - tgt_pose[i] < step_pose[i]) begin
                cur_pose[i] = tgt_pose[i];
                left--;
              end else cur_pose[i] = cur_pose[i] - step_pose[i];
            end
          end
          if (left <= 0) in_motion = 1'b0;
          for (int i = 0; i < NSERVO; i++) begin
            g.kind = KIND_GOAL;
            g.idx = IDX_W'(i);
            g.goal = POS_W'(cur_pose[i] >> FRAC);
            g.last = (i == NSERVO - 1);
            g.moving = in_motion;
            pending_goals.push_back(g);
          end
        end
      end
    endcase
  endtask

  // result checker and stall generator
  always @(posedge clk) begin
    goal_t e;
    int gap;
    in_acc = in_valid && !in_stall;
    out_acc = out_valid && !out_stall;
    if (!rst && out_acc) begin
      goals_seen++;
      if (pending_goals.size() == 0) begin
        $error("result with nothing expected: kind %0d idx %0d goal %0d",
               kind, servo_index_res, goal_raw);
        errors++;
      end else begin
        e = pending_goals.pop_front();
        if (kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, kind); errors++;
        end
        if (servo_index_res !== e.idx) begin
          $error("servo_index_res expected %0d actual %0d", e.idx, servo_index_res);
          errors++;
        end
        if (goal_raw !== e.goal) begin
          $error("goal_raw expected %0d actual %0d", e.goal, goal_raw);
          errors++;
        end
        if (last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last); errors++;
        end
        if (moving !== e.moving) begin
          $error("moving expected %0d actual %0d", e.moving, moving); errors++;
        end
      end
    end
    if (in_acc || out_acc || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL multi_servo_pose_interpolator_core");
      $finish;
    end
    gap = $urandom_range(99);
    if (rx_gap_long) out_stall <= (gap < 85);
    else out_stall <= (gap < 25);
    if ($urandom_range(199) == 0) rx_gap_long = !rx_gap_long;
  end

  // valid stays high after an accept until the next item or a drop
  task automatic send_item(input stim_t s);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= s.op;
    servo_index <= s.idx;
    position <= s.pos;
    move_time <= s.mtime;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_pose(s);
    items_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_goals();
    idle_input();
    while (pending_goals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame(input logic [FL_W-1:0] v);
    drain_goals();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_ms = v;
  endtask

  function automatic stim_t mk(input logic [1:0] o, input int i, input int p,
                               input int t);
    stim_t s;
    s.op = o; s.idx = IDX_W'(i); s.pos = POS_W'(p); s.mtime = TIME_W'(t);
    s.typed = 1'b0; s.first_goal = '0;
    return s;
  endfunction

  function automatic stim_t rand_item(input int bias);
    stim_t s;
    int r;
    r = $urandom_range(99);
    if (r < 30) s = mk(OP_TARGET, $urandom_range(bias ? NSERVO - 1 : 31), $urandom, 0);
    else if (r < 40) s = mk(OP_LOAD, $urandom_range(bias ? NSERVO - 1 : 31), $urandom, 0);
    else if (r < 50)
      s = mk(OP_START, 0, 0, ($urandom_range(9) == 0) ? $urandom : $urandom_range(400));
    else s = mk(OP_TICK, $urandom, $urandom, $urandom);
    return s;
  endfunction

  stim_t directed[$];
  stim_t s;
  goal_t idle_goal;

  initial begin
    pose_reset();
    idle_goal = '{kind: KIND_IDLE, idx: '0, goal: '0, last: 1'b1, moving: 1'b0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle tick right after reset, typed result
    s = mk(OP_TICK, 31, 1023, 65535); s.typed = 1'b1; s.first_goal = idle_goal;
    directed.push_back(s);
    directed.push_back(mk(OP_LOAD, 0, 0, 0));
    directed.push_back(mk(OP_LOAD, 17, 1023, 0));
    directed.push_back(mk(OP_LOAD, 18, 5, 0));       // out of range, ignored
    directed.push_back(mk(OP_TARGET, 31, 7, 0));     // out of range, ignored
    directed.push_back(mk(OP_TARGET, 0, 1023, 0));
    directed.push_back(mk(OP_TARGET, 17, 0, 0));
    directed.push_back(mk(OP_TARGET, 5, 100, 0));
    directed.push_back(mk(OP_START, 0, 0, 0));       // one frame, snaps
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_TICK, 0, 0, 0));        // idle tick, all arrived on the tick before
    directed.push_back(mk(OP_TARGET, 3, 600, 0));
    directed.push_back(mk(OP_START, 0, 0, 100));
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_START, 0, 0, 65535));   // restart while moving
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    directed.push_back(mk(OP_TARGET, 3, 512, 0));
    directed.push_back(mk(OP_START, 0, 0, 33));      // exact step case
    for (int k = 0; k < 4; k++) directed.push_back(mk(OP_TICK, 0, 0, 0));

    foreach (directed[k]) begin
      send_item(directed[k]);
      if (directed[k].typed && pending_goals.size() != 0
          && pending_goals[0] != directed[k].first_goal) begin
        $error("typed row %0d differs from table", k); errors++;
      end
    end

    // random phases across frame lengths, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_frame(10'd1);
        1: write_frame(10'd1023);
        2: write_frame(10'd0);
        3: write_frame(10'($urandom_range(2, 200)));
        default: write_frame(10'd33);
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        send_item(rand_item($urandom_range(9) != 0));
        // sender holds off until all goals are back
        if (k == 40) begin
          idle_input();
          while (pending_goals.size() != 0) @(posedge clk);
        end
      end
      // finish any move with a one-frame restart so phases start idle
      if (in_motion) begin
        send_item(mk(OP_START, 0, 0, 0));
        send_item(mk(OP_TICK, 0, 0, 0));
      end
      while (in_motion) send_item(mk(OP_TICK, 0, 0, 0));
    end

    drain_goals();
    $display("covered %0d items, %0d move starts, %0d results checked",
             items_sent, moves_started, goals_seen);
    $display("frame lengths 0, 1, 1023, random and 33 with random idle and stall");
    if (errors == 0) $display("PASS multi_servo_pose_interpolator_core");
    else $display("FAIL multi_servo_pose_interpolator_core");
    $finish;
  end
endmodule
